// ===== design/bleasm_pkg.sv =====
// ----------------------------------------------------------------------------
// bleasm_pkg
// Shared codes and constants for the BLE advertising signature matcher:
// walk phases, AD types, UUIDs, company IDs, hit bits and result codes.
// ----------------------------------------------------------------------------
package bleasm_pkg;

   // Longest advert walked; bytes beyond it are ignored
   localparam int ADV_BYTES_MAX_DEF = 255;

   // Walk phase codes
   localparam logic [1:0] PH_LEN  = 2'd0;
   localparam logic [1:0] PH_TYPE = 2'd1;
   localparam logic [1:0] PH_BODY = 2'd2;
   localparam logic [1:0] PH_STOP = 2'd3;

   // AD field types
   localparam logic [7:0] KIND_PARTIAL  = 8'h02;
   localparam logic [7:0] KIND_COMPLETE = 8'h03;
   localparam logic [7:0] KIND_SVC      = 8'h16;
   localparam logic [7:0] KIND_MFG      = 8'hFF;

   // 16-bit UUIDs and company identifiers
   localparam logic [15:0] UUID_RID    = 16'hFFFA;
   localparam logic [15:0] UUID_TRK_A  = 16'hFEED;
   localparam logic [15:0] UUID_TRK_B  = 16'hFD5A;
   localparam logic [15:0] UUID_FPAIR  = 16'hFE2C;
   localparam logic [15:0] CO_FINDNET  = 16'h004C;
   localparam logic [15:0] CO_TAGMAKER = 16'h0075;
   localparam logic [15:0] CO_WEAR_A   = 16'h01AB;
   localparam logic [15:0] CO_WEAR_B   = 16'h058E;

   // Single-byte markers
   localparam logic [7:0] RID_APP = 8'h0D;
   localparam logic [7:0] FN_TYPE = 8'h12;
   localparam logic [7:0] FN_LEN  = 8'h19;

   // Hit bit positions
   localparam int HIT_RID       = 0;
   localparam int HIT_FN        = 1;
   localparam int HIT_CO        = 2;
   localparam int HIT_WEAR      = 3;
   localparam int HIT_TRKA      = 4;
   localparam int HIT_TRKB_LIST = 5;
   localparam int HIT_TRKB_SVC  = 6;
   localparam int HIT_FPAIR     = 7;

   // First-seen mark bit positions
   localparam int MARK_RID      = 0;
   localparam int MARK_MFG      = 1;
   localparam int MARK_COMPLETE = 2;
   localparam int MARK_PARTIAL  = 3;

   // Signature codes
   localparam logic [2:0] SIG_NONE     = 3'd0;
   localparam logic [2:0] SIG_RID      = 3'd1;
   localparam logic [2:0] SIG_FINDNET  = 3'd2;
   localparam logic [2:0] SIG_TAGMAKER = 3'd3;
   localparam logic [2:0] SIG_WEAR     = 3'd4;
   localparam logic [2:0] SIG_TRK_A    = 3'd5;
   localparam logic [2:0] SIG_TRK_B    = 3'd6;
   localparam logic [2:0] SIG_FPAIR    = 3'd7;

   // Device class codes
   localparam logic [1:0] CLS_NONE    = 2'd0;
   localparam logic [1:0] CLS_DRONE   = 2'd1;
   localparam logic [1:0] CLS_TRACKER = 2'd2;
   localparam logic [1:0] CLS_GLASSES = 2'd3;

   // Evidence kind codes
   localparam logic [1:0] EVK_NONE = 2'd0;
   localparam logic [1:0] EVK_UUID = 2'd1;
   localparam logic [1:0] EVK_MFG  = 2'd2;

   // One result
   typedef struct packed {
      logic       matched;
      logic [2:0] signature;
      logic [1:0] device_class;
      logic [1:0] evidence_kind;
   } result_type;

endpackage

// ===== design/ble_adv_signature_matcher_core.sv =====
// ----------------------------------------------------------------------------
// ble_adv_signature_matcher_core
// Walks the length-type-value fields of a BLE advertising payload, one byte
// per request, and on the final byte returns the highest-priority tracker,
// drone or wearable signature seen. Each byte updates the field-walk
// registers as it is taken, and the result of a final byte sits in the
// response register in the cycle after. A request is taken in every cycle
// save a final byte, which waits only while the previous result is untaken.
// ----------------------------------------------------------------------------
module ble_adv_signature_matcher_core #(
   parameter int ADV_BYTES_MAX = bleasm_pkg::ADV_BYTES_MAX_DEF
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_adv_byte,
   input  logic       req_last_byte,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic       rsp_matched,
   output logic [2:0] rsp_signature,
   output logic [1:0] rsp_device_class,
   output logic [1:0] rsp_evidence_kind
);

   localparam int CW = $clog2(ADV_BYTES_MAX + 1);

   // Field-walk state
   logic [1:0]  phase_ff, phase_in;
   logic [7:0]  length_ff, length_in;
   logic [7:0]  kind_ff, kind_in;
   logic [7:0]  offset_ff, offset_in;
   logic [23:0] head_ff, head_in;
   logic [7:0]  pair_ff, pair_in;
   logic [7:0]  pending_ff, pending_in;
   logic [7:0]  committed_ff, committed_in;
   logic [3:0]  marks_ff, marks_in;
   logic        active_ff, active_in;
   logic [CW-1:0] count_ff, count_in;

   // Response register
   logic                   rsp_valid_ff, rsp_valid_in;
   bleasm_pkg::result_type rsp_ff, rsp_in;

   logic        take;
   logic        take_last;
   logic [3:0]  mark;
   logic [15:0] word;

   // Hold a final byte only while an untaken result would be overwritten
   assign req_ready = !rsp_valid_ff || rsp_ready || !req_last_byte;
   assign take      = req_valid && req_ready;
   assign take_last = take && req_last_byte;

   // Advance the field walk by one byte
   always_comb begin
      phase_in     = phase_ff;
      length_in    = length_ff;
      kind_in      = kind_ff;
      offset_in    = offset_ff;
      head_in      = head_ff;
      pair_in      = pair_ff;
      pending_in   = pending_ff;
      committed_in = committed_ff;
      marks_in     = marks_ff;
      active_in    = active_ff;
      count_in     = count_ff;
      mark         = 4'd0;
      word         = 16'd0;

      if (take && (count_ff < CW'(ADV_BYTES_MAX))) begin
         count_in = count_ff + CW'(1);
         case (phase_ff)
            bleasm_pkg::PH_LEN: begin
               if (req_adv_byte == 8'd0) begin
                  phase_in = bleasm_pkg::PH_STOP;
               end else begin
                  length_in = req_adv_byte;
                  phase_in  = bleasm_pkg::PH_TYPE;
               end
            end
            bleasm_pkg::PH_TYPE: begin
               kind_in    = req_adv_byte;
               offset_in  = 8'd0;
               head_in    = 24'd0;
               pending_in = 8'd0;
               active_in  = 1'b0;
               if (req_adv_byte == bleasm_pkg::KIND_MFG) begin
                  mark[bleasm_pkg::MARK_MFG] = 1'b1;
               end else if (req_adv_byte == bleasm_pkg::KIND_COMPLETE) begin
                  mark[bleasm_pkg::MARK_COMPLETE] = 1'b1;
               end else if (req_adv_byte == bleasm_pkg::KIND_PARTIAL) begin
                  mark[bleasm_pkg::MARK_PARTIAL] = 1'b1;
               end
               if ((mark != 4'd0) && ((marks_ff & mark) == 4'd0)) begin
                  marks_in  = marks_ff | mark;
                  active_in = 1'b1;
               end
               // A type-only field completes at once with no hits
               if (length_ff == 8'd1) begin
                  phase_in = bleasm_pkg::PH_LEN;
               end else begin
                  phase_in = bleasm_pkg::PH_BODY;
               end
            end
            bleasm_pkg::PH_BODY: begin
               // Capture the first three body bytes
               case (offset_ff)
                  8'd0:    head_in[7:0]   = req_adv_byte;
                  8'd1:    head_in[15:8]  = req_adv_byte;
                  8'd2:    head_in[23:16] = req_adv_byte;
                  default: ;
               endcase

               if ((kind_ff == bleasm_pkg::KIND_MFG) && active_ff && (offset_ff == 8'd3)) begin
                  if ((head_ff[15:0] == bleasm_pkg::CO_FINDNET)
                      && (head_ff[23:16] == bleasm_pkg::FN_TYPE)
                      && (req_adv_byte == bleasm_pkg::FN_LEN)) begin
                     pending_in[bleasm_pkg::HIT_FN] = 1'b1;
                  end else if (head_ff[15:0] == bleasm_pkg::CO_TAGMAKER) begin
                     pending_in[bleasm_pkg::HIT_CO] = 1'b1;
                  end else if ((head_ff[15:0] == bleasm_pkg::CO_WEAR_A)
                               || (head_ff[15:0] == bleasm_pkg::CO_WEAR_B)) begin
                     pending_in[bleasm_pkg::HIT_WEAR] = 1'b1;
                  end
               end else if (kind_ff == bleasm_pkg::KIND_SVC) begin
                  if (offset_ff == 8'd1) begin
                     word = {req_adv_byte, head_ff[7:0]};
                     if (word == bleasm_pkg::UUID_TRK_B) begin
                        pending_in[bleasm_pkg::HIT_TRKB_SVC] = 1'b1;
                     end else if (word == bleasm_pkg::UUID_FPAIR) begin
                        pending_in[bleasm_pkg::HIT_FPAIR] = 1'b1;
                     end else if ((word == bleasm_pkg::UUID_RID)
                                  && !marks_ff[bleasm_pkg::MARK_RID]) begin
                        marks_in[bleasm_pkg::MARK_RID] = 1'b1;
                        active_in = 1'b1;
                     end
                  end else if ((offset_ff == 8'd2) && active_ff
                               && (req_adv_byte == bleasm_pkg::RID_APP)) begin
                     pending_in[bleasm_pkg::HIT_RID] = 1'b1;
                  end
               end else if (((kind_ff == bleasm_pkg::KIND_COMPLETE)
                             || (kind_ff == bleasm_pkg::KIND_PARTIAL)) && active_ff) begin
                  if (!offset_ff[0]) begin
                     pair_in = req_adv_byte;
                  end else begin
                     word = {req_adv_byte, pair_ff};
                     if (word == bleasm_pkg::UUID_TRK_A) begin
                        pending_in[bleasm_pkg::HIT_TRKA] = 1'b1;
                     end else if (word == bleasm_pkg::UUID_TRK_B) begin
                        pending_in[bleasm_pkg::HIT_TRKB_LIST] = 1'b1;
                     end
                  end
               end

               // Commit the field's hits once its last body byte is in
               offset_in = offset_ff + 8'd1;
               if (offset_in >= (length_ff - 8'd1)) begin
                  committed_in = committed_ff | pending_in;
                  pending_in   = 8'd0;
                  phase_in     = bleasm_pkg::PH_LEN;
               end
            end
            default: ;
         endcase
      end

      // Build the result and clear the per-advert state on the final byte
      rsp_in = rsp_ff;
      if (take_last) begin
         rsp_in.signature     = bleasm_pkg::SIG_NONE;
         rsp_in.device_class  = bleasm_pkg::CLS_NONE;
         rsp_in.evidence_kind = bleasm_pkg::EVK_NONE;
         if (committed_in[bleasm_pkg::HIT_RID]) begin
            rsp_in.signature     = bleasm_pkg::SIG_RID;
            rsp_in.device_class  = bleasm_pkg::CLS_DRONE;
            rsp_in.evidence_kind = bleasm_pkg::EVK_UUID;
         end else if (committed_in[bleasm_pkg::HIT_FN]) begin
            rsp_in.signature     = bleasm_pkg::SIG_FINDNET;
            rsp_in.device_class  = bleasm_pkg::CLS_TRACKER;
            rsp_in.evidence_kind = bleasm_pkg::EVK_MFG;
         end else if (committed_in[bleasm_pkg::HIT_CO]) begin
            rsp_in.signature     = bleasm_pkg::SIG_TAGMAKER;
            rsp_in.device_class  = bleasm_pkg::CLS_TRACKER;
            rsp_in.evidence_kind = bleasm_pkg::EVK_MFG;
         end else if (committed_in[bleasm_pkg::HIT_WEAR]) begin
            rsp_in.signature     = bleasm_pkg::SIG_WEAR;
            rsp_in.device_class  = bleasm_pkg::CLS_GLASSES;
            rsp_in.evidence_kind = bleasm_pkg::EVK_MFG;
         end else if (committed_in[bleasm_pkg::HIT_TRKA]) begin
            rsp_in.signature     = bleasm_pkg::SIG_TRK_A;
            rsp_in.device_class  = bleasm_pkg::CLS_TRACKER;
            rsp_in.evidence_kind = bleasm_pkg::EVK_UUID;
         end else if (committed_in[bleasm_pkg::HIT_TRKB_LIST]
                      || committed_in[bleasm_pkg::HIT_TRKB_SVC]) begin
            rsp_in.signature     = bleasm_pkg::SIG_TRK_B;
            rsp_in.device_class  = bleasm_pkg::CLS_TRACKER;
            rsp_in.evidence_kind = bleasm_pkg::EVK_UUID;
         end else if (committed_in[bleasm_pkg::HIT_FPAIR]) begin
            rsp_in.signature     = bleasm_pkg::SIG_FPAIR;
            rsp_in.device_class  = bleasm_pkg::CLS_TRACKER;
            rsp_in.evidence_kind = bleasm_pkg::EVK_UUID;
         end
         rsp_in.matched = (rsp_in.signature != bleasm_pkg::SIG_NONE);

         phase_in     = bleasm_pkg::PH_LEN;
         length_in    = 8'd0;
         kind_in      = 8'd0;
         offset_in    = 8'd0;
         head_in      = 24'd0;
         pair_in      = 8'd0;
         pending_in   = 8'd0;
         committed_in = 8'd0;
         marks_in     = 4'd0;
         active_in    = 1'b0;
         count_in     = '0;
      end

      rsp_valid_in = take_last || (rsp_valid_ff && !rsp_ready);
   end

   // Update walk state and response valid
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= bleasm_pkg::PH_LEN;
         length_ff    <= 8'd0;
         kind_ff      <= 8'd0;
         offset_ff    <= 8'd0;
         head_ff      <= 24'd0;
         pair_ff      <= 8'd0;
         pending_ff   <= 8'd0;
         committed_ff <= 8'd0;
         marks_ff     <= 4'd0;
         active_ff    <= 1'b0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         length_ff    <= length_in;
         kind_ff      <= kind_in;
         offset_ff    <= offset_in;
         head_ff      <= head_in;
         pair_ff      <= pair_in;
         pending_ff   <= pending_in;
         committed_ff <= committed_in;
         marks_ff     <= marks_in;
         active_ff    <= active_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Hold the response payload
   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_matched       = rsp_ff.matched;
   assign rsp_signature     = rsp_ff.signature;
   assign rsp_device_class  = rsp_ff.device_class;
   assign rsp_evidence_kind = rsp_ff.evidence_kind;

`ifndef SYNTHESIS
   // The match flag agrees with the signature code
   a_matched_code : assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_ff.matched == (rsp_ff.signature != bleasm_pkg::SIG_NONE)))
      else $error("matched flag disagrees with signature");

   // A final byte leaves the walk cleared for the next advert
   a_clear_after_last : assert property (@(posedge clock) disable iff (reset)
      take_last |=> ((phase_ff == bleasm_pkg::PH_LEN) && (committed_ff == 8'd0)
                     && (marks_ff == 4'd0) && (count_ff == '0)))
      else $error("per-advert state not cleared after final byte");

   // Uncommitted hits exist only inside a field body
   a_pending_in_body : assert property (@(posedge clock) disable iff (reset)
      (pending_ff != 8'd0) |-> (phase_ff == bleasm_pkg::PH_BODY))
      else $error("pending hits outside a field body");

   // The byte count never passes the advert limit
   a_count_limit : assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(ADV_BYTES_MAX))
      else $error("byte count beyond advert limit");
`endif

endmodule

// ===== dv/ble_adv_signature_checker.sv =====
// ----------------------------------------------------------------------------
// ble_adv_signature_checker
// Watches the request and response channels of the advertising signature
// matcher. It walks every accepted byte through its own length-type-value
// parser, predicts the report of each advert on its final byte, and
// compares every accepted response field by field with the oldest
// prediction.
// ----------------------------------------------------------------------------
module ble_adv_signature_checker
   import bleasm_pkg::*;
#(
   parameter int ADV_BYTES_MAX = ADV_BYTES_MAX_DEF
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  logic       req_ready,
   input  logic [7:0] req_adv_byte,
   input  logic       req_last_byte,
   input  logic       rsp_valid,
   input  logic       rsp_ready,
   input  logic       rsp_matched,
   input  logic [2:0] rsp_signature,
   input  logic [1:0] rsp_device_class,
   input  logic [1:0] rsp_evidence_kind,
   output int         error_count,
   output int         reports_due,
   output int         reports_checked,
   output int         reports_matched,
   output logic [7:0] signatures_seen
);
   timeunit 1ns;
   timeprecision 1ps;

   // Parser state of the advert being walked
   logic [1:0]  scan_phase;
   logic [7:0]  fld_len;
   logic [7:0]  fld_kind;
   logic [7:0]  body_idx;
   logic [23:0] head;
   logic [7:0]  pair_lo;
   logic [7:0]  field_hits;
   logic [7:0]  advert_hits;
   logic [3:0]  seen_marks;
   logic        field_live;
   int          bytes_taken;

   // Reports predicted but not yet returned, oldest first
   result_type  due_reports[$];

   function automatic void clear_advert();
      scan_phase  = PH_LEN;
      fld_len     = '0;
      fld_kind    = '0;
      body_idx    = '0;
      head        = '0;
      pair_lo     = '0;
      field_hits  = '0;
      advert_hits = '0;
      seen_marks  = '0;
      field_live  = 1'b0;
      bytes_taken = 0;
   endfunction

   // Commit the hits of a finished field and look for the next length byte
   function automatic void close_field();
      advert_hits = advert_hits | field_hits;
      field_hits  = '0;
      scan_phase  = PH_LEN;
   endfunction

   function automatic void take_kind(input logic [7:0] v);
      int mark;
      fld_kind   = v;
      body_idx   = '0;
      head       = '0;
      field_hits = '0;
      field_live = 1'b0;
      mark       = -1;
      if (v == KIND_MFG) mark = MARK_MFG;
      else if (v == KIND_COMPLETE) mark = MARK_COMPLETE;
      else if (v == KIND_PARTIAL) mark = MARK_PARTIAL;
      // only the first manufacturer, complete or partial list field is live
      if (mark >= 0 && !seen_marks[mark]) begin
         seen_marks[mark] = 1'b1;
         field_live       = 1'b1;
      end
      if (fld_len == 8'd1) close_field();
      else scan_phase = PH_BODY;
   endfunction

   function automatic void take_body(input logic [7:0] v);
      logic [7:0]  b;
      logic [15:0] word;
      b    = body_idx;
      word = '0;
      if (b < 8'd3) head[8*b +: 8] = v;

      if (fld_kind == KIND_MFG && field_live && b == 8'd3) begin
         // company id plus the two bytes that follow it
         word = head[15:0];
         if (word == CO_FINDNET && head[23:16] == FN_TYPE && v == FN_LEN)
            field_hits[HIT_FN] = 1'b1;
         else if (word == CO_TAGMAKER)
            field_hits[HIT_CO] = 1'b1;
         else if (word == CO_WEAR_A || word == CO_WEAR_B)
            field_hits[HIT_WEAR] = 1'b1;
      end else if (fld_kind == KIND_SVC) begin
         if (b == 8'd1) begin
            word = head[15:0];
            if (word == UUID_TRK_B) begin
               field_hits[HIT_TRKB_SVC] = 1'b1;
            end else if (word == UUID_FPAIR) begin
               field_hits[HIT_FPAIR] = 1'b1;
            end else if (word == UUID_RID && !seen_marks[MARK_RID]) begin
               seen_marks[MARK_RID] = 1'b1;
               field_live           = 1'b1;
            end
         end else if (b == 8'd2 && field_live && v == RID_APP) begin
            field_hits[HIT_RID] = 1'b1;
         end
      end else if ((fld_kind == KIND_COMPLETE || fld_kind == KIND_PARTIAL) && field_live) begin
         // little-endian UUID pairs; an odd trailing byte never completes
         if (!b[0]) begin
            pair_lo = v;
         end else begin
            word = {v, pair_lo};
            if (word == UUID_TRK_A) field_hits[HIT_TRKA] = 1'b1;
            else if (word == UUID_TRK_B) field_hits[HIT_TRKB_LIST] = 1'b1;
         end
      end

      body_idx = b + 8'd1;
      if (body_idx >= fld_len - 8'd1) close_field();
   endfunction

   // Pick the highest-priority signature among the committed hits
   function automatic result_type judge_advert();
      result_type r;
      if (advert_hits[HIT_RID])
         r = '{1'b1, SIG_RID, CLS_DRONE, EVK_UUID};
      else if (advert_hits[HIT_FN])
         r = '{1'b1, SIG_FINDNET, CLS_TRACKER, EVK_MFG};
      else if (advert_hits[HIT_CO])
         r = '{1'b1, SIG_TAGMAKER, CLS_TRACKER, EVK_MFG};
      else if (advert_hits[HIT_WEAR])
         r = '{1'b1, SIG_WEAR, CLS_GLASSES, EVK_MFG};
      else if (advert_hits[HIT_TRKA])
         r = '{1'b1, SIG_TRK_A, CLS_TRACKER, EVK_UUID};
      else if (advert_hits[HIT_TRKB_LIST] || advert_hits[HIT_TRKB_SVC])
         r = '{1'b1, SIG_TRK_B, CLS_TRACKER, EVK_UUID};
      else if (advert_hits[HIT_FPAIR])
         r = '{1'b1, SIG_FPAIR, CLS_TRACKER, EVK_UUID};
      else
         r = '{1'b0, SIG_NONE, CLS_NONE, EVK_NONE};
      return r;
   endfunction

   function automatic void walk_adv_byte(input logic [7:0] v, input logic last);
      // bytes past the payload limit are dropped
      if (bytes_taken < ADV_BYTES_MAX) begin
         bytes_taken++;
         case (scan_phase)
            PH_LEN: begin
               if (v == 8'h00) begin
                  scan_phase = PH_STOP;
               end else begin
                  fld_len    = v;
                  scan_phase = PH_TYPE;
               end
            end
            PH_TYPE: take_kind(v);
            PH_BODY: take_body(v);
            default: ;
         endcase
      end
      if (last) begin
         due_reports.push_back(judge_advert());
         clear_advert();
      end
   endfunction

   function automatic void check_field(input string name, input int want, input int got);
      if (want != got) begin
         error_count++;
         $error("%s: expected %0d, got %0d", name, want, got);
      end
   endfunction

   // Check responses first: a response never belongs to a request of the same edge
   always @(posedge clock) begin : monitor
      result_type want;
      if (reset) begin
         clear_advert();
         due_reports.delete();
         reports_due     = 0;
         signatures_seen = '0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (due_reports.size() == 0) begin
               error_count++;
               $error("response with no prediction waiting");
            end else begin
               want = due_reports.pop_front();
               check_field("matched", want.matched, rsp_matched);
               check_field("signature", want.signature, rsp_signature);
               check_field("device_class", want.device_class, rsp_device_class);
               check_field("evidence_kind", want.evidence_kind, rsp_evidence_kind);
               reports_checked++;
               if (want.matched) reports_matched++;
               signatures_seen[want.signature] = 1'b1;
            end
         end
         if (req_valid && req_ready) walk_adv_byte(req_adv_byte, req_last_byte);
         reports_due = due_reports.size();
      end
   end

endmodule

// ===== dv/tb_ble_adv_signature_matcher_core.sv =====
// ----------------------------------------------------------------------------
// tb_ble_adv_signature_matcher_core
// Feeds the advertising signature matcher with adverts one byte per request:
// a few hand-built adverts, then random ones built mostly from well-formed
// fields that carry the recognized signatures, with truncated, terminated,
// oversized and noise adverts mixed in. Both channels idle at random and
// the response side holds off once for a long stretch.
// ----------------------------------------------------------------------------
module tb_ble_adv_signature_matcher_core;
   timeunit 1ns;
   timeprecision 1ps;

   import bleasm_pkg::*;

   localparam int ITEM_TARGET   = 1450;
   localparam int HOLD_AFTER    = 20;
   localparam int HOLD_CYCLES   = 400;
   localparam int DRAIN_CYCLES  = 8;
   localparam int TIME_LIMIT_NS = 2_000_000;

   localparam logic [15:0] COMPANY_IDS [4] = '{CO_TAGMAKER, CO_WEAR_A, CO_WEAR_B, CO_FINDNET};
   localparam logic [15:0] LIST_UUIDS  [4] = '{UUID_TRK_A, UUID_TRK_B, UUID_FPAIR, UUID_RID};
   localparam logic [7:0]  EXAMINED_KINDS [4] = '{KIND_MFG, KIND_COMPLETE, KIND_PARTIAL, KIND_SVC};

   // Field templates for the random adverts
   typedef enum int {
      FLD_DRONE_ID,
      FLD_SVC_TRACK,
      FLD_SVC_OTHER,
      FLD_FINDNET,
      FLD_COMPANY,
      FLD_MFG_OTHER,
      FLD_UUID_LIST,
      FLD_EMPTY,
      FLD_OTHER
   } field_pick_type;

   logic       clock;
   logic       reset         = 1'b1;
   logic       req_valid     = 1'b0;
   logic       req_ready;
   logic [7:0] req_adv_byte  = 8'h00;
   logic       req_last_byte = 1'b0;
   logic       rsp_valid;
   logic       rsp_ready     = 1'b0;
   logic       rsp_matched;
   logic [2:0] rsp_signature;
   logic [1:0] rsp_device_class;
   logic [1:0] rsp_evidence_kind;

   int         error_count;
   int         reports_due;
   int         reports_checked;
   int         reports_matched;
   logic [7:0] signatures_seen;

   logic       burst;
   int         bytes_sent;
   int         adverts_sent;
   logic [7:0] advert_q[$];
   logic [7:0] body_q[$];

   ble_adv_signature_matcher_core uut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_adv_byte      (req_adv_byte),
      .req_last_byte     (req_last_byte),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_matched       (rsp_matched),
      .rsp_signature     (rsp_signature),
      .rsp_device_class  (rsp_device_class),
      .rsp_evidence_kind (rsp_evidence_kind)
   );

   ble_adv_signature_checker sig_check (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_adv_byte      (req_adv_byte),
      .req_last_byte     (req_last_byte),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_matched       (rsp_matched),
      .rsp_signature     (rsp_signature),
      .rsp_device_class  (rsp_device_class),
      .rsp_evidence_kind (rsp_evidence_kind),
      .error_count       (error_count),
      .reports_due       (reports_due),
      .reports_checked   (reports_checked),
      .reports_matched   (reports_matched),
      .signatures_seen   (signatures_seen)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // Hard stop in case the handshakes hang
   initial begin
      #(TIME_LIMIT_NS);
      $display("timeout: %0d reports still due", reports_due);
      $display("Some tests failed");
      $finish;
   end

   // Offer one byte and hold it until the request is taken
   task automatic send_byte(input logic [7:0] b, input logic last);
      int gap;
      gap = burst ? 0 : $urandom_range(0, 5);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_adv_byte  <= b;
      req_last_byte <= last;
      do @(posedge clock); while (!req_ready);
   endtask

   task automatic send_advert();
      burst = ($urandom_range(0, 3) == 0);
      foreach (advert_q[i]) begin
         send_byte(advert_q[i], i == advert_q.size() - 1);
         bytes_sent++;
      end
      adverts_sent++;
   endtask

   task automatic push_body_word(input logic [15:0] w);
      body_q.push_back(w[7:0]);
      body_q.push_back(w[15:8]);
   endtask

   // Append one length-type-value field built from a random template
   task automatic add_field();
      field_pick_type pick;
      logic [7:0]     kind;
      int             extra;
      int             idx;
      body_q.delete();
      pick  = field_pick_type'($urandom_range(0, int'(FLD_OTHER)));
      extra = 0;
      case (pick)
         FLD_DRONE_ID: begin
            kind = KIND_SVC;
            push_body_word(UUID_RID);
            if ($urandom_range(0, 4) != 0) begin
               body_q.push_back(($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255)) : RID_APP);
               extra = $urandom_range(0, 3);
            end
         end
         FLD_SVC_TRACK: begin
            kind = KIND_SVC;
            push_body_word(($urandom_range(0, 1) == 0) ? UUID_TRK_B : UUID_FPAIR);
            extra = $urandom_range(0, 4);
         end
         FLD_SVC_OTHER: begin
            kind  = KIND_SVC;
            extra = $urandom_range(0, 6);
         end
         FLD_FINDNET: begin
            kind = KIND_MFG;
            push_body_word(CO_FINDNET);
            body_q.push_back(FN_TYPE);
            body_q.push_back(FN_LEN);
            // spoil one header byte now and then
            if ($urandom_range(0, 3) == 0) begin
               idx         = $urandom_range(0, 3);
               body_q[idx] = 8'($urandom_range(0, 255));
            end
            extra = $urandom_range(0, 6);
         end
         FLD_COMPANY: begin
            kind = KIND_MFG;
            push_body_word(COMPANY_IDS[$urandom_range(0, 3)]);
            extra = $urandom_range(0, 5);
         end
         FLD_MFG_OTHER: begin
            kind  = KIND_MFG;
            extra = $urandom_range(0, 8);
         end
         FLD_UUID_LIST: begin
            kind = ($urandom_range(0, 1) == 0) ? KIND_COMPLETE : KIND_PARTIAL;
            repeat ($urandom_range(0, 4)) begin
               if ($urandom_range(0, 4) == 0) push_body_word(16'($urandom_range(0, 65535)));
               else push_body_word(LIST_UUIDS[$urandom_range(0, 3)]);
            end
            if ($urandom_range(0, 3) == 0) extra = 1;
         end
         FLD_EMPTY: begin
            if ($urandom_range(0, 4) == 0) kind = 8'($urandom_range(0, 255));
            else kind = EXAMINED_KINDS[$urandom_range(0, 3)];
         end
         default: begin
            kind  = 8'($urandom_range(0, 255));
            extra = $urandom_range(0, 10);
         end
      endcase
      repeat (extra) body_q.push_back(8'($urandom_range(0, 255)));
      advert_q.push_back(8'(body_q.size() + 1));
      advert_q.push_back(kind);
      foreach (body_q[i]) advert_q.push_back(body_q[i]);
   endtask

   // Mostly well-formed adverts; some end early, some stop at a zero length
   task automatic build_advert();
      int tail;
      advert_q.delete();
      if ($urandom_range(0, 19) < 2) begin
         repeat ($urandom_range(1, 40)) advert_q.push_back(8'($urandom_range(0, 255)));
      end else begin
         repeat ($urandom_range(1, 4)) add_field();
         case ($urandom_range(0, 9))
            0, 1: begin
               advert_q.push_back(8'h00);
               repeat ($urandom_range(0, 4)) advert_q.push_back(8'($urandom_range(0, 255)));
            end
            2: begin
               tail = $urandom_range(1, 3);
               while (tail > 0 && advert_q.size() > 1) begin
                  void'(advert_q.pop_back());
                  tail--;
               end
            end
            default: ;
         endcase
      end
   endtask

   // One field that fills the payload limit exactly, or overruns it by one
   task automatic build_long_advert(input logic overrun);
      int total;
      advert_q.delete();
      advert_q.push_back(overrun ? 8'hFF : 8'hFE);
      advert_q.push_back(KIND_MFG);
      advert_q.push_back(CO_TAGMAKER[7:0]);
      advert_q.push_back(CO_TAGMAKER[15:8]);
      total = ADV_BYTES_MAX_DEF + 1 + $urandom_range(0, 6);
      while (advert_q.size() < total) advert_q.push_back(8'($urandom_range(0, 255)));
   endtask

   // Take responses with random waits and one long hold-off
   initial begin : receiver
      int   gap;
      int   taken;
      logic calm;
      taken = 0;
      calm  = 1'b0;
      @(negedge reset);
      forever begin
         if (taken % 8 == 0) calm = ($urandom_range(0, 2) == 0);
         gap = calm ? 0 : $urandom_range(0, 5);
         if (taken == HOLD_AFTER) gap = HOLD_CYCLES;
         if (gap > 0) begin
            rsp_ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
         taken++;
      end
   end

   initial begin : stimulus
      int adv_idx;
      bytes_sent   = 0;
      adverts_sent = 0;
      burst        = 1'b0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // zero length right away: walk stops, no signature
      advert_q = '{8'h00};
      send_advert();
      // empty manufacturer field, then a drone id service data
      advert_q = '{8'h01, KIND_MFG, 8'h04, KIND_SVC, UUID_RID[7:0], UUID_RID[15:8], RID_APP};
      send_advert();
      // wearable company outranks a tag UUID in the complete list
      advert_q = '{8'h05, KIND_MFG, CO_WEAR_A[7:0], CO_WEAR_A[15:8], 8'hFF, 8'h00,
                   8'h03, KIND_COMPLETE, UUID_TRK_A[7:0], UUID_TRK_A[15:8]};
      send_advert();
      // find-network header in a field cut short by the end of the advert
      advert_q = '{8'h06, KIND_MFG, CO_FINDNET[7:0], CO_FINDNET[15:8], FN_TYPE, FN_LEN};
      send_advert();

      adv_idx = 0;
      while (bytes_sent < ITEM_TARGET) begin
         if (adv_idx == 8 || adv_idx == 30) build_long_advert(adv_idx == 30);
         else build_advert();
         send_advert();
         adv_idx++;
      end
      req_valid <= 1'b0;

      do @(negedge clock); while (reports_due != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("sent %0d bytes in %0d adverts; %0d reports checked, %0d with a signature",
               bytes_sent, adverts_sent, reports_checked, reports_matched);
      $display("signature codes reported (bit per code): %b", signatures_seen);
      if (error_count == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
design/bleasm_pkg.sv
design/ble_adv_signature_matcher_core.sv
dv/ble_adv_signature_checker.sv
dv/tb_ble_adv_signature_matcher_core.sv
